/* rtl/core/wtsp_pkg.sv */
// Shared types and constants for the world-to-screen projector.
`timescale 1ns / 1ps
`default_nettype none
package wtsp_pkg;

    localparam int COORD_W = 32;
    localparam int PROD_W  = 64;
    localparam int CLIP_W  = 67;
    localparam int NUM_W   = 68;
    localparam int REM_W   = 68;
    localparam int N_W     = 98;
    localparam int Q_W     = 32;
    localparam int FRAC_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [Q_W-1:0] SENTINEL = 32'hD8F0_0000;
    localparam logic [Q_W-1:0] SAT_POS  = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] SAT_NEG  = 32'h8000_0000;

    typedef struct packed {
        logic signed [CLIP_W-1:0] cx;
        logic signed [CLIP_W-1:0] cy;
        logic signed [CLIP_W-1:0] cw;
    } clip_t;

    typedef struct packed {
        logic [REM_W-1:0] r;
        logic [Q_W-1:0]   q;
        logic [Q_W-1:0]   nlow;
        logic             ovf;
        logic             neg;
    } div_lane_t;

    typedef struct packed {
        div_lane_t        lx;
        div_lane_t        ly;
        logic [NUM_W-1:0] d;
        logic             zero;
    } div_item_t;

endpackage
`default_nettype wire

/* rtl/core/wtsp_front.sv */
// Front end: matrix registers and the row-vector times matrix product.
`timescale 1ns / 1ps
`default_nettype none
module wtsp_front
    import wtsp_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic signed [COORD_W-1:0]    world_x,
    input  wire logic signed [COORD_W-1:0]    world_y,
    input  wire logic signed [COORD_W-1:0]    world_z,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data,
    input  wire logic                         q_full,
    output logic                              q_push,
    output clip_t                             q_data
);

    // columns 0, 1 and 3 of each row; column 2 feeds nothing
    logic signed [COORD_W-1:0] mx_reg [4];
    logic signed [COORD_W-1:0] my_reg [4];
    logic signed [COORD_W-1:0] mw_reg [4];

    logic signed [COORD_W-1:0] p_reg [3];
    logic signed [PROD_W-1:0]  px_reg [3];
    logic signed [PROD_W-1:0]  py_reg [3];
    logic signed [PROD_W-1:0]  pw_reg [3];
    logic signed [CLIP_W-1:0]  tx_reg, ty_reg, tw_reg;
    logic signed [CLIP_W-1:0]  ax_reg, ay_reg, aw_reg;
    logic signed [CLIP_W-1:0]  bx_reg, by_reg, bw_reg;
    clip_t                     c_reg;
    logic                      v0_reg, v1_reg, v2_reg, v3_reg;
    logic                      en;

    assign en     = !(v3_reg && q_full);
    assign full   = !en;
    assign q_push = v3_reg && !q_full;
    assign q_data = c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mx_reg[i] <= '0;
                my_reg[i] <= '0;
                mw_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (!cfg_index[0])
            begin
                mx_reg[cfg_index[2:1]] <= cfg_data[31:0];
                my_reg[cfg_index[2:1]] <= cfg_data[63:32];
            end
            else
            begin
                mw_reg[cfg_index[2:1]] <= cfg_data[63:32];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= push;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= world_x;
            p_reg[1] <= world_y;
            p_reg[2] <= world_z;
            for (int r = 0; r < 3; r++)
            begin
                px_reg[r] <= PROD_W'(p_reg[r]) * PROD_W'(mx_reg[r]);
                py_reg[r] <= PROD_W'(p_reg[r]) * PROD_W'(my_reg[r]);
                pw_reg[r] <= PROD_W'(p_reg[r]) * PROD_W'(mw_reg[r]);
            end
            // translation row scaled by w = 1.0
            tx_reg <= CLIP_W'(mx_reg[3]) <<< FRAC_W;
            ty_reg <= CLIP_W'(my_reg[3]) <<< FRAC_W;
            tw_reg <= CLIP_W'(mw_reg[3]) <<< FRAC_W;
            ax_reg <= CLIP_W'(px_reg[0]) + CLIP_W'(px_reg[1]);
            ay_reg <= CLIP_W'(py_reg[0]) + CLIP_W'(py_reg[1]);
            aw_reg <= CLIP_W'(pw_reg[0]) + CLIP_W'(pw_reg[1]);
            bx_reg <= CLIP_W'(px_reg[2]) + tx_reg;
            by_reg <= CLIP_W'(py_reg[2]) + ty_reg;
            bw_reg <= CLIP_W'(pw_reg[2]) + tw_reg;
            c_reg.cx <= ax_reg + bx_reg;
            c_reg.cy <= ay_reg + by_reg;
            c_reg.cw <= aw_reg + bw_reg;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/wtsp_fifo.sv */
// Four-entry queue of clip coordinates between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module wtsp_fifo
    import wtsp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr,
    input  wire clip_t wr_data,
    output logic       q_full,
    input  wire logic  rd,
    output clip_t      rd_data,
    output logic       q_empty
);

    clip_t       mem_reg [4];
    logic [1:0]  wp_reg, rp_reg;
    logic [2:0]  cnt_reg;
    logic        do_wr, do_rd;

    assign q_full  = (cnt_reg == 3'd4);
    assign q_empty = (cnt_reg == 3'd0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= wp_reg + 2'd1;
            if (do_rd)
                rp_reg <= rp_reg + 2'd1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 3'd1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule
`default_nettype wire

/* rtl/core/wtsp_back.sv */
// Back end: viewport scaling, pipelined divide and saturation.
`timescale 1ns / 1ps
`default_nettype none
module wtsp_back
    import wtsp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1280,
    parameter int SCREEN_HEIGHT = 720
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_empty,
    input  wire clip_t                    q_data,
    output logic                          q_pop,
    output logic                          empty,
    input  wire logic                     pop,
    output logic signed [Q_W-1:0]         screen_x,
    output logic signed [Q_W-1:0]         screen_y,
    output logic                          w_was_zero
);

    logic                     en;
    logic                     v0_reg, v1_reg, v2_reg, vo_reg;
    logic                     vd_reg [Q_W+1];

    logic signed [NUM_W-1:0]  nx0_reg, ny0_reg, cw0_reg;
    logic [NUM_W-1:0]         ax1_reg, ay1_reg, d1_reg;
    logic                     negx1_reg, negy1_reg, zero1_reg;
    logic [N_W-1:0]           nx2_reg, ny2_reg;
    logic [NUM_W-1:0]         d2_reg;
    logic                     negx2_reg, negy2_reg, zero2_reg;
    div_item_t                dv_reg  [Q_W+1];
    div_item_t                dv_next [Q_W+1];
    logic [Q_W-1:0]           sx_reg, sy_reg;
    logic                     z_reg;

    assign en         = !vo_reg || pop;
    assign q_pop      = en && !q_empty;
    assign empty      = !vo_reg;
    assign screen_x   = sx_reg;
    assign screen_y   = sy_reg;
    assign w_was_zero = z_reg;

    function automatic div_lane_t lane_init(input logic [N_W-1:0] n,
                                            input logic [NUM_W-1:0] d,
                                            input logic neg);
        div_lane_t l;
        l.ovf  = (n >> Q_W) >= N_W'(d);
        l.r    = REM_W'(n >> Q_W);
        l.q    = '0;
        l.nlow = n[Q_W-1:0];
        l.neg  = neg;
        return l;
    endfunction

    function automatic div_lane_t lane_step(input div_lane_t l,
                                            input logic [NUM_W-1:0] d);
        div_lane_t o;
        logic [REM_W:0] t;
        o = l;
        t = {l.r, l.nlow[Q_W-1]};
        o.nlow = {l.nlow[Q_W-2:0], 1'b0};
        if (t >= (REM_W+1)'(d))
        begin
            o.r = REM_W'(t - (REM_W+1)'(d));
            o.q = {l.q[Q_W-2:0], 1'b1};
        end
        else
        begin
            o.r = REM_W'(t);
            o.q = {l.q[Q_W-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [Q_W-1:0] lane_out(input div_lane_t l);
        logic [Q_W-1:0] v;
        if (l.neg)
            v = (l.ovf || l.q > SAT_NEG) ? SAT_NEG : Q_W'(-l.q);
        else
            v = (l.ovf || l.q[Q_W-1]) ? SAT_POS : l.q;
        return v;
    endfunction

    always_comb
    begin
        dv_next[0].lx   = lane_init(nx2_reg, d2_reg, negx2_reg);
        dv_next[0].ly   = lane_init(ny2_reg, d2_reg, negy2_reg);
        dv_next[0].d    = d2_reg;
        dv_next[0].zero = zero2_reg;
        for (int k = 1; k <= Q_W; k++)
        begin
            dv_next[k].lx   = lane_step(dv_reg[k-1].lx, dv_reg[k-1].d);
            dv_next[k].ly   = lane_step(dv_reg[k-1].ly, dv_reg[k-1].d);
            dv_next[k].d    = dv_reg[k-1].d;
            dv_next[k].zero = dv_reg[k-1].zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int k = 0; k <= Q_W; k++)
                vd_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= !q_empty;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            vd_reg[0] <= v2_reg;
            for (int k = 1; k <= Q_W; k++)
                vd_reg[k] <= vd_reg[k-1];
            vo_reg    <= vd_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // numerators cw + cx and cw - cy
            nx0_reg <= NUM_W'(q_data.cw) + NUM_W'(q_data.cx);
            ny0_reg <= NUM_W'(q_data.cw) - NUM_W'(q_data.cy);
            cw0_reg <= NUM_W'(q_data.cw);

            ax1_reg   <= nx0_reg[NUM_W-1] ? NUM_W'(-nx0_reg) : nx0_reg;
            ay1_reg   <= ny0_reg[NUM_W-1] ? NUM_W'(-ny0_reg) : ny0_reg;
            d1_reg    <= (cw0_reg[NUM_W-1] ? NUM_W'(-cw0_reg) : cw0_reg) << 1;
            negx1_reg <= nx0_reg[NUM_W-1] ^ cw0_reg[NUM_W-1];
            negy1_reg <= ny0_reg[NUM_W-1] ^ cw0_reg[NUM_W-1];
            zero1_reg <= (cw0_reg == '0);

            nx2_reg   <= (N_W'(ax1_reg) * N_W'(SCREEN_WIDTH)) << FRAC_W;
            ny2_reg   <= (N_W'(ay1_reg) * N_W'(SCREEN_HEIGHT)) << FRAC_W;
            d2_reg    <= d1_reg;
            negx2_reg <= negx1_reg;
            negy2_reg <= negy1_reg;
            zero2_reg <= zero1_reg;

            for (int k = 0; k <= Q_W; k++)
                dv_reg[k] <= dv_next[k];

            if (dv_reg[Q_W].zero)
            begin
                sx_reg <= SENTINEL;
                sy_reg <= SENTINEL;
                z_reg  <= 1'b1;
            end
            else
            begin
                sx_reg <= lane_out(dv_reg[Q_W].lx);
                sy_reg <= lane_out(dv_reg[Q_W].ly);
                z_reg  <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/world_to_screen_projector_core.sv */
// Top level of the world-to-screen projector: front end, queue, back end.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel   Handshake        Payload
//  --------  ---------------  ---------------------------------------------
//  input     push / full      world_x, world_y, world_z (signed Q16.16)
//  result    pop / empty      screen_x, screen_y (Q16.16), w_was_zero
//  config    cfg_we           cfg_index (0..7), cfg_data (two Q16.16 words)
//
//  One point per clock sustained while results are popped. The input
//  transfer edge loads the first of 42 register stages: 4 in the matrix
//  multiply, 1 through the queue, 4 for viewport scaling, 32 for the
//  one-bit-per-stage quotient and 1 for saturation into the result register.
//  Reset clears the matrix to zero and empties every stage.
//  A stalled result halts the back end; the 4-entry queue lets the front
//  end keep taking points until it fills, then full rises.
//
module world_to_screen_projector_core
    import wtsp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1280,
    parameter int SCREEN_HEIGHT = 720
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic signed [COORD_W-1:0]  world_x,
    input  wire logic signed [COORD_W-1:0]  world_y,
    input  wire logic signed [COORD_W-1:0]  world_z,
    input  wire logic                       pop,
    output logic                            empty,
    output logic signed [Q_W-1:0]           screen_x,
    output logic signed [Q_W-1:0]           screen_y,
    output logic                            w_was_zero,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data
);

    // front to queue
    logic  f_push;
    clip_t f_data;
    logic  q_full;
    // queue to back
    logic  q_empty;
    logic  q_pop;
    clip_t q_data;

    wtsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .world_x   (world_x),
        .world_y   (world_y),
        .world_z   (world_z),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (f_push),
        .q_data    (f_data)
    );

    wtsp_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_push),
        .wr_data (f_data),
        .q_full  (q_full),
        .rd      (q_pop),
        .rd_data (q_data),
        .q_empty (q_empty)
    );

    // back end advances whenever its result register is free or taken
    wtsp_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .screen_x   (screen_x),
        .screen_y   (screen_y),
        .w_was_zero (w_was_zero)
    );

endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for world_to_screen_projector_core.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import wtsp_pkg::*;

    localparam int WIDTH_PX  = 1280;
    localparam int HEIGHT_PX = 720;
    localparam int DRAIN_CYCLES = 100;

    // Register indexes of the matrix halves
    localparam logic [CFG_IDX_W-1:0] REG_R0_LEFT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_R0_RIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R1_LEFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R1_RIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_R2_LEFT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_R2_RIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_R3_LEFT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_R3_RIGHT = 3'd7;

    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic        wz;
    } screen_pt_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic signed [31:0] world_x = '0, world_y = '0, world_z = '0;
    logic pop = 1'b0;
    logic empty;
    logic signed [31:0] screen_x, screen_y;
    logic w_was_zero;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Local copy of the matrix, m[row][col] as Q16.16 words
    logic [31:0] proj_mat [4][4];
    screen_pt_t  expected_pts[$];
    int          mismatch_cnt = 0;
    bit          pop_idle_allowed = 1'b1;

    world_to_screen_projector_core #(
        .SCREEN_WIDTH (WIDTH_PX),
        .SCREEN_HEIGHT(HEIGHT_PX)
    ) i_dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .world_x(world_x), .world_y(world_y), .world_z(world_z),
        .pop(pop), .empty(empty),
        .screen_x(screen_x), .screen_y(screen_y), .w_was_zero(w_was_zero),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // size * num / (2 * den) in Q16.16, truncated toward zero, saturated
    function automatic logic [31:0] viewport_coord(logic signed [127:0] num,
                                                   logic signed [127:0] den,
                                                   int size);
        logic [127:0] n_abs, d_abs, quo;
        bit neg;
        neg   = (num < 0) != (den < 0);
        n_abs = (num < 0) ? -num : num;
        d_abs = (den < 0) ? -den : den;
        quo   = (n_abs * 128'(size) * 128'd65536) / (d_abs * 128'd2);
        if (neg)
        begin
            if (quo > 128'h8000_0000) return SAT_NEG;
            return 32'(-quo);
        end
        if (quo > 128'h7FFF_FFFF) return SAT_POS;
        return quo[31:0];
    endfunction

    function automatic logic signed [127:0] clip_sum(logic signed [31:0] px,
                                                     logic signed [31:0] py,
                                                     logic signed [31:0] pz,
                                                     int col);
        logic signed [127:0] acc;
        acc = 128'(signed'(proj_mat[3][col])) * 128'sd65536;
        acc += 128'(px) * 128'(signed'(proj_mat[0][col]));
        acc += 128'(py) * 128'(signed'(proj_mat[1][col]));
        acc += 128'(pz) * 128'(signed'(proj_mat[2][col]));
        return acc;
    endfunction

    function automatic screen_pt_t project_point(logic signed [31:0] px,
                                                 logic signed [31:0] py,
                                                 logic signed [31:0] pz);
        logic signed [127:0] cx, cy, cw;
        screen_pt_t pt;
        cx = clip_sum(px, py, pz, 0);
        cy = clip_sum(px, py, pz, 1);
        cw = clip_sum(px, py, pz, 3);
        if (cw == 0)
        begin
            pt.sx = SENTINEL;
            pt.sy = SENTINEL;
            pt.wz = 1'b1;
        end
        else
        begin
            pt.sx = viewport_coord(cw + cx, cw, WIDTH_PX);
            pt.sy = viewport_coord(cw - cy, cw, HEIGHT_PX);
            pt.wz = 1'b0;
        end
        return pt;
    endfunction

    // Register write, only while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        proj_mat[idx >> 1][(idx & 1) * 2]     = val[31:0];
        proj_mat[idx >> 1][(idx & 1) * 2 + 1] = val[63:32];
    endtask

    task automatic load_matrix(logic [31:0] m [4][4]);
        write_reg(REG_R0_LEFT,  {m[0][1], m[0][0]});
        write_reg(REG_R0_RIGHT, {m[0][3], m[0][2]});
        write_reg(REG_R1_LEFT,  {m[1][1], m[1][0]});
        write_reg(REG_R1_RIGHT, {m[1][3], m[1][2]});
        write_reg(REG_R2_LEFT,  {m[2][1], m[2][0]});
        write_reg(REG_R2_RIGHT, {m[2][3], m[2][2]});
        write_reg(REG_R3_LEFT,  {m[3][1], m[3][0]});
        write_reg(REG_R3_RIGHT, {m[3][3], m[3][2]});
    endtask

    // One point transfer; predicts at acceptance, leaves push high
    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push    <= 1'b1;
        world_x <= px;
        world_y <= py;
        world_z <= pz;
        @(posedge clk);
        while (full) @(posedge clk);
        expected_pts.push_back(project_point(px, py, pz));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        push <= 1'b0;
        while (expected_pts.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Random Q16.16 value: mostly moderate, sometimes any 32-bit pattern
    function automatic logic [31:0] rand_q16();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
        if (r < 8) return 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_entry();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return 32'h0;
        if (r < 8) return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        return $urandom;
    endfunction

    // Identity-like perspective: cw = z, so z = 0 hits the zero-w case
    task automatic test_directed();
        logic [31:0] m [4][4];
        logic [31:0] edges [6];
        edges = '{32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h0000_0001};
        foreach (m[r, c]) m[r][c] = 32'h0;
        m[0][0] = 32'h0001_0000;
        m[1][1] = 32'h0001_0000;
        m[2][2] = 32'h0001_0000;
        m[2][3] = 32'h0001_0000;
        load_matrix(m);
        send_point(32'h0, 32'h0, 32'h0);                       // w zero
        send_point(32'h0, 32'h0, 32'h0001_0000);               // screen center
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000); // corner
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001); // saturates
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
        send_point(32'h0000_8000, 32'h0000_8000, 32'hFFFF_0000); // negative w
        for (int i = 0; i < 6; i++)
            send_point(edges[i], edges[5 - i], edges[(i + 2) % 6]);
        wait_idle();
        // extreme register words: 8000_0000 on the diagonal, 7FFF_FFFF elsewhere
        foreach (m[r, c]) m[r][c] = (r == c) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        load_matrix(m);
        for (int i = 0; i < 6; i++)
            send_point(edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6]);
        wait_idle();
    endtask

    task automatic test_random_matrices();
        logic [31:0] m [4][4];
        for (int phase = 0; phase < 12; phase++)
        begin
            foreach (m[r, c]) m[r][c] = rand_entry();
            if (phase % 4 == 0) m[3][3] = 32'h0; // w purely from the point
            load_matrix(m);
            pop_idle_allowed = (phase % 3 != 1);
            for (int i = 0; i < 95; i++)
            begin
                // a share of points with zero w via zero coordinates
                if (phase % 4 == 0 && $urandom_range(0, 9) == 0)
                    send_point(32'h0, 32'h0, 32'h0);
                else
                    send_point(rand_q16(), rand_q16(), rand_q16());
            end
            wait_idle();
        end
        pop_idle_allowed = 1'b1;
    endtask

    // Result side: random pop gaps unless pop_idle_allowed is clear, checks each transfer
    initial
    begin
        int gap;
        screen_pt_t want;
        @(posedge rst_n);
        forever
        begin
            gap = pop_idle_allowed ? pick_gap() : 0;
            @(negedge clk);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            if (expected_pts.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result x=%h y=%h wz=%b",
                             screen_x, screen_y, w_was_zero);
            end
            else
            begin
                want = expected_pts.pop_front();
                if (screen_x !== want.sx || screen_y !== want.sy
                    || w_was_zero !== want.wz)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp x=%h y=%h wz=%b act x=%h y=%h wz=%b",
                                 want.sx, want.sy, want.wz,
                                 screen_x, screen_y, w_was_zero);
                end
            end
        end
    end

    initial
    begin
        foreach (proj_mat[r, c]) proj_mat[r][c] = 32'h0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // reset matrix is all zero: every point gives the zero-w sentinel
        send_point(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
        wait_idle();
        test_directed();
        test_random_matrices();
        if (mismatch_cnt == 0 && expected_pts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
